### src/rad_pkg.sv
package rad_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_DIG2CP = 2'd2,
    REQ_CP2DIG = 2'd3
  } req_e_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_MISS      = 3'd1,
    STS_BAD_RANGE = 3'd2,
    STS_TOO_MANY  = 3'd3,
    STS_OVERLAP   = 3'd4,
    STS_FULL      = 3'd5
  } status_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e_t;

  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST  = 21'h00D800;
  localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
  localparam logic [20:0] UPPER_A     = 21'h000041;
  localparam logic [20:0] UPPER_Z     = 21'h00005A;
  localparam logic [32:0] TOTAL_LIMIT = 33'h080000000;

  // one row of the range table
  typedef struct packed {
    logic [20:0] cp_lo;
    logic [20:0] cp_hi;
    logic [30:0] base;
  } entry_t;

  // one result word
  typedef struct packed {
    status_e_t   status;
    logic [20:0] symbol;
    logic [30:0] digit;
    logic [31:0] size;
    logic        upper;
    logic        encodable;
  } res_t;

endpackage

### src/rad_table.sv
module rad_table import rad_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/rad_seq.sv
module rad_seq import rad_pkg::*; #(
  parameter int MAX_RANGES = 16,
  parameter int AW         = 4,
  parameter int CW         = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    req_type,
  input  logic [20:0]   range_first,
  input  logic [20:0]   range_last,
  input  logic [30:0]   digit_in,
  input  logic [20:0]   code_point,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_data,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_data
);

  state_e_t state, state_next;

  // item registers
  req_e_t      req;
  logic [20:0] first;
  logic [20:0] last;
  logic [30:0] digit;
  logic [20:0] cp;

  // table status
  logic [CW-1:0] count, count_next;
  logic [31:0]   total, total_next;
  logic          upper, upper_next;
  logic          sfree, sfree_next;

  // scan
  logic [CW-1:0] idx;
  logic          chk_vld;
  logic          issue;
  logic          hit;
  logic [30:0]   val;

  logic [21:0]   len;
  logic [32:0]   new_total;
  status_e_t     pre_status;
  logic          skip;
  logic          finish;

  logic [21:0]   e_len;
  logic [30:0]   d_diff;
  logic          chk_hit;
  logic [30:0]   chk_val;
  logic          commit;
  logic          append_ok;

  // append prechecks, in priority order
  always_comb begin
    len       = {1'b0, last} - {1'b0, first} + 22'd1;
    new_total = {1'b0, total} + 33'(len);
    if (first > last || last > CP_MAX) begin
      pre_status = STS_BAD_RANGE;
    end else if (count == CW'(MAX_RANGES)) begin
      pre_status = STS_FULL;
    end else if (new_total > TOTAL_LIMIT) begin
      pre_status = STS_TOO_MANY;
    end else begin
      pre_status = STS_OK;
    end
  end

  assign skip = (req == REQ_APPEND && pre_status != STS_OK) ||
                (req == REQ_DIG2CP && {1'b0, digit} >= total);

  // per-entry check on the row read last cycle
  always_comb begin
    e_len   = {1'b0, rd_data.cp_hi} - {1'b0, rd_data.cp_lo} + 22'd1;
    d_diff  = digit - rd_data.base;
    chk_hit = 1'b0;
    chk_val = '0;
    case (req)
      REQ_APPEND: begin
        chk_hit = (first <= rd_data.cp_hi) && (last >= rd_data.cp_lo);
      end
      REQ_DIG2CP: begin
        chk_hit = (digit >= rd_data.base) && (d_diff < 31'(e_len));
        chk_val = 31'(rd_data.cp_lo + d_diff[20:0]);
      end
      REQ_CP2DIG: begin
        chk_hit = (cp >= rd_data.cp_lo) && (cp <= rd_data.cp_hi);
        chk_val = rd_data.base + 31'(cp - rd_data.cp_lo);
      end
      default: begin
        chk_hit = 1'b0;
      end
    endcase
  end

  assign issue  = (idx < count);
  assign finish = skip || (chk_vld && chk_hit) || (!issue && !chk_vld);
  assign rd_addr = idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (req_e_t'(req_type) == REQ_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result and table status after the item
  always_comb begin
    res        = '0;
    count_next = count;
    total_next = total;
    upper_next = upper;
    sfree_next = sfree;
    append_ok  = 1'b0;
    res.status = STS_OK;
    case (req)
      REQ_CLEAR: begin
        count_next = '0;
        total_next = '0;
        upper_next = 1'b0;
        sfree_next = 1'b1;
      end
      REQ_APPEND: begin
        if (pre_status != STS_OK) begin
          res.status = pre_status;
        end else if (hit) begin
          res.status = STS_OVERLAP;
        end else begin
          append_ok  = 1'b1;
          count_next = count + CW'(1);
          total_next = new_total[31:0];
          if (first <= UPPER_Z && last >= UPPER_A) begin
            upper_next = 1'b1;
          end
          if (first <= SURR_LAST && last >= SURR_FIRST) begin
            sfree_next = 1'b0;
          end
        end
      end
      REQ_DIG2CP: begin
        res.status = hit ? STS_OK : STS_MISS;
        res.symbol = hit ? val[20:0] : '0;
      end
      default: begin
        res.status = hit ? STS_OK : STS_MISS;
        res.digit  = hit ? val : '0;
      end
    endcase
    res.size      = total_next;
    res.upper     = upper_next;
    res.encodable = sfree_next;
  end

  assign commit        = (state == ST_DONE) && res_ready;
  assign wr_en         = commit && append_ok;
  assign wr_addr       = count[AW-1:0];
  assign wr_data.cp_lo = first;
  assign wr_data.cp_hi = last;
  assign wr_data.base  = total[30:0];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      total   <= '0;
      upper   <= 1'b0;
      sfree   <= 1'b1;
      chk_vld <= 1'b0;
      idx     <= '0;
    end else begin
      if (state == ST_IDLE) begin
        idx     <= '0;
        chk_vld <= 1'b0;
      end else if (state == ST_SCAN) begin
        idx     <= idx + CW'(issue);
        chk_vld <= issue;
      end
      if (commit) begin
        count <= count_next;
        total <= total_next;
        upper <= upper_next;
        sfree <= sfree_next;
      end
    end
  end

  // item and scan payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req   <= req_e_t'(req_type);
      first <= range_first;
      last  <= range_last;
      digit <= digit_in;
      cp    <= code_point;
      hit   <= 1'b0;
    end else if (state == ST_SCAN) begin
      hit <= !skip && chk_vld && chk_hit;
      val <= chk_val;
    end
  end

endmodule

### src/range_alphabet_digit_translator.sv
// Range alphabet digit translator. Holds up to MAX_RANGES code point ranges
// in load order and numbers their symbols densely as digits: range 0 holds
// digits 0.., each later range continues where the one before it stopped.
// req_type picks the operation: clear empties the table; append checks the
// range (backwards or above U+10FFFF, table full, total past 2^31, overlap
// with any loaded range, in that order) and adds it only if all pass;
// digit-to-code-point and code-point-to-digit look up the table and report
// "not in alphabet" on a miss. Every word in gives exactly one word out,
// carrying the status plus the alphabet size and the uppercase and
// surrogate-free flags as they stand after that word. The ranges live in a
// single-port-read synchronous memory that is scanned one row per cycle; a
// lookup stops at its first hit, and a clear or an append that fails the
// range, full or size check skips the scan. One item is worked on at a
// time; input is taken again as soon as the result has moved into the
// output register, even while that register waits on out_ready. The table
// needs no clearing after reset: only rows below the loaded count are ever
// used.
module range_alphabet_digit_translator import rad_pkg::*; #(
  parameter int MAX_RANGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [20:0] range_first,
  input  logic [20:0] range_last,
  input  logic [30:0] digit_in,
  input  logic [20:0] code_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [20:0] symbol_out,
  output logic [30:0] digit_out,
  output logic [31:0] alphabet_size,
  output logic        has_upper,
  output logic        encodable
);

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  res_t          out_q;

  rad_seq #(
    .MAX_RANGES (MAX_RANGES),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .range_first (range_first),
    .range_last  (range_last),
    .digit_in    (digit_in),
    .code_point  (code_point),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  // range table: start, end and base digit of each loaded range
  rad_table #(
    .DEPTH (MAX_RANGES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register; the sequencer commits the item when this slot frees up
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign status        = out_q.status;
  assign symbol_out    = out_q.symbol;
  assign digit_out     = out_q.digit;
  assign alphabet_size = out_q.size;
  assign has_upper     = out_q.upper;
  assign encodable     = out_q.encodable;

`ifndef SYNTH
  // one item in flight: no second word right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // an uppercase flag needs at least one symbol loaded
  a_upper_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && has_upper) |-> (alphabet_size != 32'd0))
    else $error("has_upper set on an empty alphabet");

  // surrogate flag clears only when some range is loaded
  a_surr_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !encodable) |-> (alphabet_size != 32'd0))
    else $error("encodable clear on an empty alphabet");

  // total never passes 2^31
  a_size_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alphabet_size <= 32'h80000000))
    else $error("alphabet size beyond limit");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
